// ----- rtl/dltq_pkg.sv -----
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types, constants and control words for the delta-list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int IDX_W      = $clog2(MAX_TIMERS);
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
  localparam int TIME_W     = 24;
  localparam int ID_W       = 16;
  localparam int ENTRY_W    = TIME_W + ID_W;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [1:0] POS_HEAD   = 2'd0;
  localparam logic [1:0] POS_MIDDLE = 2'd1;
  localparam logic [1:0] POS_TAIL   = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [ID_W-1:0]   seq_no;
    logic [TIME_W-1:0] time_value;
  } item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [1:0]      position;
    logic            expired;
    logic [ID_W-1:0] expired_seq;
    logic            now_empty;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] delta;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_KM1,
    RD_KP1
  } rsel_t;

  typedef enum logic [2:0] {
    W_SHIFT,
    W_FIRST,
    W_TAIL,
    W_HEAD_SUB,
    W_ADJ,
    W_NEW
  } wsel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_AREQ,
    S_AEVAL,
    S_UPCHK,
    S_UPREQ,
    S_UPWR,
    S_ADJ,
    S_NEW,
    S_CREQ,
    S_CEVAL,
    S_TREQ,
    S_TEVAL,
    S_DNCHK,
    S_DNREQ,
    S_DNWR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       load_item;
    rsel_t      rd_sel;
    logic       wr_en;
    wsel_t      wr_sel;
    logic       idx_inc;
    logic       sum_acc;
    logic       save_rd;
    logic       k_from_idx;
    logic       k_from_count;
    logic       merge_set;
    logic       k_dec;
    logic       k_inc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_load;
    logic [2:0] res_status;
    logic [1:0] res_pos;
    logic       exp_load;
    logic       publish;
  } ctl_t;

  typedef struct packed {
    logic [1:0] command;
    logic       zero_time;
    logic       full;
    logic       empty;
    logic       add_hit;
    logic       last;
    logic       idx_zero;
    logic       id_hit;
    logic       tick_exp;
    logic       up_more;
    logic       down_more;
    logic       out_free;
  } stat_t;

endpackage

// ----- rtl/delta_list_timer_queue.sv -----
// Sequence: dispatch, then a request and an evaluate state per entry scanned and
//   a check, a request and a write state per entry moved; a rejected or trivial
//   command goes from dispatch straight to the result.
// Throughput: one command at a time; the next word is taken once the current
//   result is in the output register. Registered RAM reads set the pace.
// Reset: synchronous; empties the list and drops any pending result word.
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Delta-list timer queue with add, tick and cancel commands.
// ----------------------------------------------------------------------------
module delta_list_timer_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  dltq_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output dltq_pkg::result_t result
);
  import dltq_pkg::*;

  ctl_t  ctl;
  stat_t st;

  dltq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .st         (st),
    .ctl        (ctl)
  );

  dltq_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .ctl          (ctl),
    .st           (st),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- rtl/dltq_ram.sv -----
// ----------------------------------------------------------------------------
// dltq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/dltq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer for add, tick and cancel: walks the list one entry at a time
// and steers the datapath through scans and shifts.
// ----------------------------------------------------------------------------
module dltq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  dltq_pkg::stat_t st,
  output dltq_pkg::ctl_t  ctl
);
  import dltq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.rd_sel = RD_IDX;
    ctl.wr_sel = W_SHIFT;
    item_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_DISP;
        end
      end
      S_DISP: begin
        ctl.res_load   = 1'b1;
        ctl.res_status = ST_OK;
        ctl.res_pos    = POS_HEAD;
        state_next     = S_DONE;
        case (st.command)
          CMD_ADD: begin
            if (st.zero_time) begin
              ctl.res_status = ST_ZERO;
            end else if (st.full) begin
              ctl.res_status = ST_FULL;
            end else if (st.empty) begin
              ctl.wr_en   = 1'b1;
              ctl.wr_sel  = W_FIRST;
              ctl.cnt_inc = 1'b1;
            end else begin
              ctl.res_load = 1'b0;
              state_next   = S_AREQ;
            end
          end
          CMD_TICK: begin
            if (st.empty) begin
              ctl.res_status = ST_EMPTY;
            end else begin
              ctl.res_load = 1'b0;
              state_next   = S_TREQ;
            end
          end
          CMD_CANCEL: begin
            if (st.empty) begin
              ctl.res_status = ST_EMPTY;
            end else begin
              ctl.res_load = 1'b0;
              state_next   = S_CREQ;
            end
          end
          default: ;
        endcase
      end
      S_AREQ: begin
        state_next = S_AEVAL;
      end
      S_AEVAL: begin
        ctl.res_status = ST_OK;
        if (st.add_hit) begin
          // insert before this entry; open a gap above it
          ctl.save_rd      = 1'b1;
          ctl.k_from_count = 1'b1;
          ctl.res_load     = 1'b1;
          ctl.res_pos      = st.idx_zero ? POS_HEAD : POS_MIDDLE;
          state_next       = S_UPCHK;
        end else if (st.last) begin
          ctl.wr_en    = 1'b1;
          ctl.wr_sel   = W_TAIL;
          ctl.cnt_inc  = 1'b1;
          ctl.res_load = 1'b1;
          ctl.res_pos  = POS_TAIL;
          state_next   = S_DONE;
        end else begin
          ctl.idx_inc = 1'b1;
          ctl.sum_acc = 1'b1;
          state_next  = S_AREQ;
        end
      end
      S_UPCHK: begin
        state_next = st.up_more ? S_UPREQ : S_ADJ;
      end
      S_UPREQ: begin
        ctl.rd_sel = RD_KM1;
        state_next = S_UPWR;
      end
      S_UPWR: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = W_SHIFT;
        ctl.k_dec  = 1'b1;
        state_next = S_UPCHK;
      end
      S_ADJ: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = W_ADJ;
        state_next = S_NEW;
      end
      S_NEW: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_sel  = W_NEW;
        ctl.cnt_inc = 1'b1;
        state_next  = S_DONE;
      end
      S_CREQ: begin
        state_next = S_CEVAL;
      end
      S_CEVAL: begin
        if (st.id_hit) begin
          ctl.save_rd    = 1'b1;
          ctl.k_from_idx = 1'b1;
          ctl.merge_set  = 1'b1;
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_OK;
          if (st.idx_zero) begin
            ctl.res_pos = POS_HEAD;
          end else if (st.last) begin
            ctl.res_pos = POS_TAIL;
          end else begin
            ctl.res_pos = POS_MIDDLE;
          end
          state_next = S_DNCHK;
        end else if (st.last) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_NOTFOUND;
          ctl.res_pos    = POS_HEAD;
          state_next     = S_DONE;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_CREQ;
        end
      end
      S_TREQ: begin
        state_next = S_TEVAL;
      end
      S_TEVAL: begin
        ctl.res_load   = 1'b1;
        ctl.res_status = ST_OK;
        ctl.res_pos    = POS_HEAD;
        if (st.tick_exp) begin
          ctl.exp_load   = 1'b1;
          ctl.k_from_idx = 1'b1;
          state_next     = S_DNCHK;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.wr_sel = W_HEAD_SUB;
          state_next = S_DONE;
        end
      end
      S_DNCHK: begin
        if (st.down_more) begin
          state_next = S_DNREQ;
        end else begin
          ctl.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DNREQ: begin
        ctl.rd_sel = RD_KP1;
        state_next = S_DNWR;
      end
      S_DNWR: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = W_SHIFT;
        ctl.k_inc  = 1'b1;
        state_next = S_DNCHK;
      end
      S_DONE: begin
        if (st.out_free) begin
          ctl.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/dltq_dpath.sv -----
// ----------------------------------------------------------------------------
// dltq_dpath
// Entry RAM, scan pointers, running sum, result staging and output register.
// ----------------------------------------------------------------------------
module dltq_dpath (
  input  logic              clk,
  input  logic              rst,
  input  dltq_pkg::item_t   item,
  input  dltq_pkg::ctl_t    ctl,
  output dltq_pkg::stat_t   st,
  output logic              result_valid,
  input  logic              result_ready,
  output dltq_pkg::result_t result
);
  import dltq_pkg::*;

  item_t               cur;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    k;
  logic [TIME_W-1:0]   sum;
  entry_t              saved;
  logic                merge;
  logic [2:0]          res_status;
  logic [1:0]          res_pos;
  logic                res_exp;
  logic [ID_W-1:0]     res_exp_seq;

  logic [ENTRY_W-1:0]  rd_raw;
  entry_t              rd;
  logic [CNT_W-1:0]    raddr_full;
  logic [CNT_W-1:0]    waddr_full;
  entry_t              wdata;
  logic [TIME_W-1:0]   nd;
  logic [TIME_W:0]     merge_sum;
  logic [TIME_W-1:0]   merge_sat;
  logic [TIME_W:0]     probe;

  assign rd        = entry_t'(rd_raw);
  assign nd        = cur.time_value - sum;
  assign merge_sum = {1'b0, rd.delta} + {1'b0, saved.delta};
  assign merge_sat = merge_sum[TIME_W] ? {TIME_W{1'b1}} : merge_sum[TIME_W-1:0];
  assign probe     = {1'b0, sum} + {1'b0, rd.delta};

  always_comb begin
    case (ctl.rd_sel)
      RD_KM1:  raddr_full = k - CNT_W'(1);
      RD_KP1:  raddr_full = k + CNT_W'(1);
      default: raddr_full = idx;
    endcase
  end

  always_comb begin
    waddr_full = k;
    wdata      = rd;
    case (ctl.wr_sel)
      W_SHIFT: begin
        waddr_full  = k;
        // the first move of a cancel carries the removed delta forward
        wdata.delta = merge ? merge_sat : rd.delta;
        wdata.id    = rd.id;
      end
      W_FIRST: begin
        waddr_full  = '0;
        wdata.delta = cur.time_value;
        wdata.id    = cur.seq_no;
      end
      W_TAIL: begin
        waddr_full  = count;
        wdata.delta = nd - rd.delta;
        wdata.id    = cur.seq_no;
      end
      W_HEAD_SUB: begin
        waddr_full  = idx;
        wdata.delta = rd.delta - cur.time_value;
        wdata.id    = rd.id;
      end
      W_ADJ: begin
        waddr_full  = idx + CNT_W'(1);
        wdata.delta = saved.delta - nd;
        wdata.id    = saved.id;
      end
      W_NEW: begin
        waddr_full  = idx;
        wdata.delta = nd;
        wdata.id    = cur.seq_no;
      end
      default: ;
    endcase
  end

  dltq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TIMERS)
  ) u_entries (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (waddr_full[IDX_W-1:0]),
    .wdata (wdata),
    .raddr (raddr_full[IDX_W-1:0]),
    .rdata (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (ctl.cnt_dec) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cur     <= item;
      idx     <= '0;
      sum     <= '0;
      merge   <= 1'b0;
      res_exp <= 1'b0;
      res_exp_seq <= '0;
    end else begin
      if (ctl.idx_inc) begin
        idx <= idx + CNT_W'(1);
      end
      if (ctl.sum_acc) begin
        sum <= sum + rd.delta;
      end
      if (ctl.k_from_idx) begin
        merge <= ctl.merge_set;
      end else if (ctl.wr_en && ctl.wr_sel == W_SHIFT) begin
        merge <= 1'b0;
      end
      if (ctl.exp_load) begin
        res_exp     <= 1'b1;
        res_exp_seq <= rd.id;
      end
    end
    if (ctl.save_rd) begin
      saved <= rd;
    end
    if (ctl.k_from_idx) begin
      k <= idx;
    end else if (ctl.k_from_count) begin
      k <= count;
    end else if (ctl.k_dec) begin
      k <= k - CNT_W'(1);
    end else if (ctl.k_inc) begin
      k <= k + CNT_W'(1);
    end
    if (ctl.res_load) begin
      res_status <= ctl.res_status;
      res_pos    <= ctl.res_pos;
    end
  end

  // output register: hold a finished word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.publish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      result.status      <= res_status;
      result.position    <= res_pos;
      result.expired     <= res_exp;
      result.expired_seq <= res_exp_seq;
      result.now_empty   <= (count == '0);
    end
  end

  assign st.command   = cur.command;
  assign st.zero_time = (cur.time_value == '0);
  assign st.full      = (count == CNT_W'(MAX_TIMERS));
  assign st.empty     = (count == '0);
  assign st.add_hit   = probe > {1'b0, cur.time_value};
  assign st.last      = ((idx + CNT_W'(1)) == count);
  assign st.idx_zero  = (idx == '0);
  assign st.id_hit    = (rd.id == cur.seq_no);
  assign st.tick_exp  = (cur.time_value >= rd.delta);
  assign st.up_more   = (k > (idx + CNT_W'(1)));
  assign st.down_more = ((k + CNT_W'(1)) < count);
  assign st.out_free  = !result_valid || result_ready;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TIMERS))
    else $error("entry count above capacity");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    ctl.cnt_inc |-> (count < CNT_W'(MAX_TIMERS)))
    else $error("add grew a full list");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.cnt_dec |-> (count != '0))
    else $error("removal from an empty list");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> (waddr_full < CNT_W'(MAX_TIMERS)))
    else $error("entry write beyond capacity");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    ctl.publish |-> (!result_valid || result_ready))
    else $error("result overwritten before it was taken");

endmodule
